[hw/rtl/tpe_pkg.sv]
// ============================================================================
// tpe_pkg
// Shared types and constants for the terrain patch edge triangle generator.
// ============================================================================
package tpe_pkg;

   localparam int MaxPatchSize = 8;
   localparam int IndexWidth   = 24;
   localparam int MaxLog       = $clog2(MaxPatchSize);
   localparam int MinLog       = 2;
   localparam int CntW         = MaxLog + 2;
   localparam int CoordW       = MaxLog + 3;
   localparam int StrideW      = 13;
   localparam int PslW         = 2;
   localparam int ScaleW       = 2;
   localparam int SideW        = 2;
   localparam int OffW         = CoordW + StrideW + 2;
   localparam int CsrIdxW      = 1;
   localparam int CsrDataW     = 13;

   localparam logic [SideW-1:0] SideTop    = 2'd0;
   localparam logic [SideW-1:0] SideLeft   = 2'd1;
   localparam logic [SideW-1:0] SideBottom = 2'd2;
   localparam logic [SideW-1:0] SideRight  = 2'd3;

   localparam logic [CsrIdxW-1:0] CsrRowStride    = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrPatchSizeLog = 1'b1;

   localparam logic [StrideW-1:0] RowStrideReset    = 13'd9;
   localparam logic [PslW-1:0]    PatchSizeLogReset = 2'd3;

   typedef struct packed {
      logic [IndexWidth-1:0] center_index;
      logic [SideW-1:0]      side;
      logic [ScaleW-1:0]     inner_scale_log;
      logic [ScaleW-1:0]     outer_scale_log;
   } req_type;

   typedef struct packed {
      logic [IndexWidth-1:0] vertex_a;
      logic [IndexWidth-1:0] vertex_b;
      logic [IndexWidth-1:0] vertex_c;
      logic                  last_triangle;
   } rsp_type;

   // grid position relative to the centre: a along the side axis, b across,
   // h adds a truncated half minor step
   typedef struct packed {
      logic signed [CoordW-1:0] a;
      logic signed [CoordW-1:0] b;
      logic signed [1:0]        h;
   } coord_type;

   typedef struct packed {
      coord_type v0;
      coord_type v1;
      coord_type v2;
   } tri_coord_type;

endpackage

[hw/rtl/tpe_coord_unit.sv]
// ============================================================================
// tpe_coord_unit
// Maps the three grid positions of one triangle to wrapped vertex indices.
// ============================================================================
module tpe_coord_unit (
   input  logic [tpe_pkg::IndexWidth-1:0] ic,
   input  logic [tpe_pkg::StrideW-1:0]    stride,
   input  logic [tpe_pkg::SideW-1:0]      side,
   input  tpe_pkg::tri_coord_type         tri_in,
   output logic [tpe_pkg::IndexWidth-1:0] idx_a,
   output logic [tpe_pkg::IndexWidth-1:0] idx_b,
   output logic [tpe_pkg::IndexWidth-1:0] idx_c
);

   function automatic logic [tpe_pkg::IndexWidth-1:0] to_index(
      input tpe_pkg::coord_type               v,
      input logic [tpe_pkg::IndexWidth-1:0] base,
      input logic [tpe_pkg::StrideW-1:0]    st,
      input logic [tpe_pkg::SideW-1:0]      sd
   );
      logic                                 lr;
      logic                                 neg;
      logic signed [tpe_pkg::CoordW-1:0]    x;
      logic signed [tpe_pkg::CoordW-1:0]    y;
      logic signed [tpe_pkg::StrideW:0]     st_s;
      logic signed [tpe_pkg::OffW-1:0]      half;
      logic signed [tpe_pkg::OffW-1:0]      off;
      lr   = (sd == tpe_pkg::SideLeft) || (sd == tpe_pkg::SideRight);
      neg  = (sd == tpe_pkg::SideBottom) || (sd == tpe_pkg::SideRight);
      x    = lr ? v.b : v.a;
      y    = lr ? -v.a : v.b;
      st_s = {1'b0, st};
      half = lr ? tpe_pkg::OffW'(signed'({2'b00, st[tpe_pkg::StrideW-1:1]})) : '0;
      off  = tpe_pkg::OffW'(x) * tpe_pkg::OffW'(st_s) + tpe_pkg::OffW'(y);
      if (v.h == 2'sb01) begin
         off = off + half;
      end else if (v.h == 2'sb11) begin
         off = off - half;
      end
      to_index = neg ? base - tpe_pkg::IndexWidth'(off) : base + tpe_pkg::IndexWidth'(off);
   endfunction

   assign idx_a = to_index(tri_in.v0, ic, stride, side);
   assign idx_b = to_index(tri_in.v1, ic, stride, side);
   assign idx_c = to_index(tri_in.v2, ic, stride, side);

endmodule

[hw/rtl/terrain_patch_edge_triangles_core.sv]
// ============================================================================
// terrain_patch_edge_triangles_core
// Emits the triangle list of one side wedge of a terrain patch, one triangle
// per cycle, walking rows and stitching fans under a small sequencer.
// ============================================================================
//
//   channel | ports                         | transfer
//   --------+-------------------------------+-------------------------------
//   request | start, busy, req_data         | edge with start=1, busy=0
//   result  | rsp_valid, rsp_data           | every cycle rsp_valid=1
//   config  | csr_wr_en, csr_index, csr_wdata | every edge with csr_wr_en=1
//
// Flow: the request is registered, then the sequencer issues one triangle
// per cycle through the coordinate unit, N triangles (1 to 32) per item.
// Results trail the sequencer by one register.
// Reset is synchronous; it restores row_stride=9, patch_size_log=3.
// The result side cannot stall; busy is the only hold on requests.
// ============================================================================
module terrain_patch_edge_triangles_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  tpe_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output tpe_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [tpe_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [tpe_pkg::CsrDataW-1:0] csr_wdata
);

   localparam int CntW   = tpe_pkg::CntW;
   localparam int CoordW = tpe_pkg::CoordW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ONE   = 3'd1;  // full-coarse wedge
   localparam logic [2:0] ST_HALF  = 3'd2;  // half level, two triangles
   localparam logic [2:0] ST_BODY  = 3'd3;  // quad pairs inside a row
   localparam logic [2:0] ST_REND  = 3'd4;  // closing pair of a row
   localparam logic [2:0] ST_SHEAD = 3'd5;  // head pair of a stitch fan
   localparam logic [2:0] ST_SSUB  = 3'd6;  // fan sub-steps

   // config
   logic [tpe_pkg::StrideW-1:0] stride_ff;
   logic [tpe_pkg::PslW-1:0]    psl_ff;

   // sequencer
   logic [2:0]      state_ff, state_in;
   logic [1:0]      k_ff, k_in;
   logic [CntW-1:0] ri_ff, ri_in;
   logic [CntW-1:0] cj_ff, cj_in;
   logic [CntW-1:0] su_ff, su_in;
   logic [CntW-1:0] sj_ff, sj_in;
   logic [CntW-1:0] js_ff, js_in;

   // request context
   logic [tpe_pkg::IndexWidth-1:0] ic_ff;
   logic [tpe_pkg::SideW-1:0]      side_ff;
   logic [CntW-1:0]                is_ff, os_ff, h_ff, range_ff, subs_ff;
   logic                           stitch_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   tpe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // request decode
   logic [tpe_pkg::PslW-1:0]   ps;
   logic [tpe_pkg::ScaleW-1:0] il, ol;
   logic [CntW-1:0]            q_v, h_v, is_v, os_v, subs_v, range_v;
   logic                       case_one, case_half, stitch_v;

   logic                   accept;
   logic                   last;
   tpe_pkg::tri_coord_type tri_c;
   logic [tpe_pkg::IndexWidth-1:0] idx_a, idx_b, idx_c;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      ps = psl_ff;
      if (ps < tpe_pkg::PslW'(tpe_pkg::MinLog)) ps = tpe_pkg::PslW'(tpe_pkg::MinLog);
      if (ps > tpe_pkg::PslW'(tpe_pkg::MaxLog)) ps = tpe_pkg::PslW'(tpe_pkg::MaxLog);
      il = (req_data.inner_scale_log > ps) ? ps : req_data.inner_scale_log;
      ol = (req_data.outer_scale_log > ps) ? ps : req_data.outer_scale_log;
      q_v       = CntW'(1) << ps;
      h_v       = q_v >> 1;
      is_v      = CntW'(1) << il;
      os_v      = CntW'(1) << ol;
      subs_v    = os_v >> (3'(il) + 3'd1);
      range_v   = (is_v != os_v) ? h_v - is_v : h_v;
      case_one  = (is_v == q_v) || ((is_v == h_v) && (os_v == q_v));
      case_half = (is_v == h_v);
      stitch_v  = (is_v != os_v) && (os_v != q_v);
   end

   function automatic tpe_pkg::coord_type mk(
      input logic signed [CoordW-1:0] a,
      input logic signed [CoordW-1:0] b,
      input logic signed [1:0]        h
   );
      tpe_pkg::coord_type r;
      r.a = a;
      r.b = b;
      r.h = h;
      mk  = r;
   endfunction

   // triangle positions for the current step
   always_comb begin
      logic signed [CoordW-1:0] i_s, c_s, s_s, i1_s, r0_s, r1_s;
      logic signed [CoordW-1:0] u_s, os_s, oh_s, js_s, h_s, ac_s, bc_s;
      logic signed [1:0]        hf;
      tpe_pkg::coord_type       p00, p01, p10, p11, q00, q01, q10, q11;
      tpe_pkg::coord_type       a10, a11, b10, b11;
      i_s  = CoordW'(ri_ff);
      c_s  = CoordW'(cj_ff);
      s_s  = CoordW'(is_ff);
      i1_s = i_s + s_s;
      r0_s = CoordW'(range_ff);
      r1_s = r0_s + s_s;
      u_s  = CoordW'(su_ff);
      os_s = CoordW'(os_ff);
      oh_s = CoordW'(os_ff >> 1);
      js_s = CoordW'(js_ff);
      h_s  = CoordW'(h_ff);
      hf   = (os_ff == CntW'(1)) ? 2'sb01 : 2'sb00;
      ac_s = u_s + oh_s;
      bc_s = -u_s - oh_s;
      p00 = mk(i_s,  c_s,        2'sb00);
      p01 = mk(i_s,  c_s + s_s,  2'sb00);
      p10 = mk(i1_s, c_s,        2'sb00);
      p11 = mk(i1_s, c_s + s_s,  2'sb00);
      q00 = mk(i_s,  -c_s,       2'sb00);
      q01 = mk(i_s,  -c_s - s_s, 2'sb00);
      q10 = mk(i1_s, -c_s,       2'sb00);
      q11 = mk(i1_s, -c_s - s_s, 2'sb00);
      a10 = mk(r1_s, u_s,         2'sb00);
      a11 = mk(r1_s, u_s + os_s,  2'sb00);
      b10 = mk(r1_s, -u_s,        2'sb00);
      b11 = mk(r1_s, -u_s - os_s, 2'sb00);
      tri_c = '0;
      unique case (state_ff)
         ST_ONE: begin
            tri_c = {mk('0, '0, 2'sb00), mk(h_s, -h_s, 2'sb00), mk(h_s, h_s, 2'sb00)};
         end
         ST_HALF: begin
            if (k_ff == 2'd0) begin
               tri_c = {mk('0, '0, 2'sb00), mk(h_s, -h_s, 2'sb00), mk(h_s, '0, 2'sb00)};
            end else begin
               tri_c = {mk('0, '0, 2'sb00), mk(h_s, '0, 2'sb00), mk(h_s, h_s, 2'sb00)};
            end
         end
         ST_BODY: begin
            case (k_ff)
               2'd0:    tri_c = {p00, p10, p11};
               2'd1:    tri_c = {p00, p11, p01};
               2'd2:    tri_c = {q00, q11, q10};
               default: tri_c = {q00, q01, q11};
            endcase
         end
         ST_REND: begin
            tri_c = (k_ff == 2'd0) ? {p00, p10, p11} : {q00, q11, q10};
         end
         ST_SHEAD: begin
            if (k_ff == 2'd0) begin
               tri_c = {a10, a11, mk(r0_s, ac_s, hf)};
            end else begin
               tri_c = {b10, mk(r0_s, bc_s, -hf), b11};
            end
         end
         ST_SSUB: begin
            case (k_ff)
               2'd0: tri_c = {a10, mk(r0_s, ac_s - js_s, hf),
                              mk(r0_s, ac_s - js_s - s_s, hf)};
               2'd1: tri_c = {b10, mk(r0_s, bc_s + js_s + s_s, -hf),
                              mk(r0_s, bc_s + js_s, -hf)};
               2'd2: tri_c = {a11, mk(r0_s, ac_s + js_s + s_s, hf),
                              mk(r0_s, ac_s + js_s, hf)};
               default: tri_c = {b11, mk(r0_s, bc_s - js_s, -hf),
                                 mk(r0_s, bc_s - js_s - s_s, -hf)};
            endcase
         end
         default: tri_c = '0;
      endcase
   end

   tpe_coord_unit u_coord (
      .ic     (ic_ff),
      .stride (stride_ff),
      .side   (side_ff),
      .tri_in (tri_c),
      .idx_a  (idx_a),
      .idx_b  (idx_b),
      .idx_c  (idx_c)
   );

   // sequencer next state
   always_comb begin
      logic [CntW-1:0] cj_n, ri_n, su_n, sj_n;
      logic            skip;
      cj_n = cj_ff + is_ff;
      ri_n = ri_ff + is_ff;
      su_n = su_ff + os_ff;
      sj_n = sj_ff + CntW'(1);
      // last sub-step of the last fan drops its outer triangle pair
      skip = (su_n == h_ff) && (sj_n == subs_ff);
      state_in = state_ff;
      k_in     = k_ff;
      ri_in    = ri_ff;
      cj_in    = cj_ff;
      su_in    = su_ff;
      sj_in    = sj_ff;
      js_in    = js_ff;
      last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = case_one ? ST_ONE : (case_half ? ST_HALF : ST_REND);
               k_in  = 2'd0;
               ri_in = '0;
               cj_in = '0;
               su_in = '0;
               sj_in = '0;
               js_in = '0;
            end
         end
         ST_ONE: begin
            last = 1'b1;
         end
         ST_HALF: begin
            if (k_ff == 2'd0) k_in = 2'd1;
            else last = 1'b1;
         end
         ST_BODY: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               cj_in    = cj_n;
               state_in = (cj_n == ri_ff) ? ST_REND : ST_BODY;
            end
         end
         ST_REND: begin
            if (k_ff == 2'd0) begin
               k_in = 2'd1;
            end else begin
               k_in = 2'd0;
               if (ri_n < range_ff) begin
                  ri_in    = ri_n;
                  cj_in    = '0;
                  state_in = ST_BODY;
               end else if (stitch_ff) begin
                  su_in    = '0;
                  state_in = ST_SHEAD;
               end else begin
                  last = 1'b1;
               end
            end
         end
         ST_SHEAD: begin
            if (k_ff == 2'd0) begin
               k_in = 2'd1;
            end else begin
               k_in = 2'd0;
               if (subs_ff != '0) begin
                  sj_in    = '0;
                  js_in    = '0;
                  state_in = ST_SSUB;
               end else if (su_n < h_ff) begin
                  su_in    = su_n;
                  state_in = ST_SHEAD;
               end else begin
                  last = 1'b1;
               end
            end
         end
         ST_SSUB: begin
            if ((k_ff == 2'd3) || ((k_ff == 2'd1) && skip)) begin
               k_in = 2'd0;
               if (skip) begin
                  last = 1'b1;
               end else if (sj_n < subs_ff) begin
                  sj_in = sj_n;
                  js_in = js_ff + is_ff;
               end else if (su_n < h_ff) begin
                  su_in    = su_n;
                  state_in = ST_SHEAD;
               end else begin
                  last = 1'b1;
               end
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (last) state_in = ST_IDLE;
   end

   always_comb begin
      rsp_valid_in              = (state_ff != ST_IDLE);
      rsp_data_in.vertex_a      = idx_a;
      rsp_data_in.vertex_b      = idx_b;
      rsp_data_in.vertex_c      = idx_c;
      rsp_data_in.last_triangle = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         stride_ff    <= tpe_pkg::RowStrideReset;
         psl_ff       <= tpe_pkg::PatchSizeLogReset;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               tpe_pkg::CsrRowStride:    stride_ff <= csr_wdata[tpe_pkg::StrideW-1:0];
               tpe_pkg::CsrPatchSizeLog: psl_ff    <= csr_wdata[tpe_pkg::PslW-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload and loop registers, no reset needed
   always_ff @(posedge clock) begin
      ri_ff       <= ri_in;
      cj_ff       <= cj_in;
      su_ff       <= su_in;
      sj_ff       <= sj_in;
      js_ff       <= js_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         ic_ff     <= req_data.center_index;
         side_ff   <= req_data.side;
         is_ff     <= is_v;
         os_ff     <= os_v;
         h_ff      <= h_v;
         range_ff  <= range_v;
         subs_ff   <= subs_v;
         stitch_ff <= stitch_v;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/tpe_checker.sv]
// ============================================================================
// tpe_checker
// Port-level checks on the terrain patch edge triangle generator.
// ============================================================================
module tpe_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input tpe_pkg::rsp_type rsp_data
);

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted but not busy");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_triangle) |=> !rsp_valid)
      else $error("result right after last triangle");

   a_result_needs_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work in progress");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_triangle) |-> busy)
      else $error("wedge ended without last triangle");

endmodule

bind terrain_patch_edge_triangles_core tpe_checker u_tpe_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

[verif/terrain_patch_edge_triangles_checker.sv]
// ============================================================================
// terrain_patch_edge_triangles_checker
// Watches the request, result and register ports. It builds the triangle list
// of each accepted wedge request and compares every result with it.
// ============================================================================
module terrain_patch_edge_triangles_checker
   import tpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  fail_count,
   output int                  triangles_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [StrideW-1:0] grid_stride;
   logic [PslW-1:0]    size_log;
   rsp_type            triangle_q[$];

   function automatic void push_triangle(longint a, longint b, longint c);
      rsp_type t;
      t.vertex_a      = a[IndexWidth-1:0];
      t.vertex_b      = b[IndexWidth-1:0];
      t.vertex_c      = c[IndexWidth-1:0];
      t.last_triangle = 1'b0;
      triangle_q.push_back(t);
   endfunction

   // Wedge triangulation: coarse cap, half level, or rows plus stitch fans.
   function automatic void predict_wedge(req_type r);
      int unsigned ps, il, ol, q_sz, h_sz, is, os, range_len, subs, first, i, j;
      longint st, maj, mnr, h_maj, h_min, i_maj, i_min, o_min, o_half, ic, m0, r0, r1;
      longint p00, p01, p10, p11, q00, q01, q10, q11;
      longint a10, a11, ac, b10, b11, bc;
      longint ac0, ac1, ax0, ax1, bc0, bc1, bx0, bx1;
      first = triangle_q.size();
      ps = size_log;
      if (ps < MinLog) ps = MinLog;
      if (ps > MaxLog) ps = MaxLog;
      il = r.inner_scale_log;
      ol = r.outer_scale_log;
      if (il > ps) il = ps;
      if (ol > ps) ol = ps;
      q_sz = 1 << ps;
      h_sz = q_sz >> 1;
      is = 1 << il;
      os = 1 << ol;
      st = longint'(grid_stride);
      case (r.side)
         SideTop: begin
            maj = st; mnr = 1;
         end
         SideLeft: begin
            maj = -1; mnr = st;
         end
         SideBottom: begin
            maj = -st; mnr = -1;
         end
         default: begin
            maj = 1; mnr = -st;
         end
      endcase
      h_maj  = longint'(h_sz) * maj;
      h_min  = longint'(h_sz) * mnr;
      i_maj  = longint'(is) * maj;
      i_min  = longint'(is) * mnr;
      o_min  = longint'(os) * mnr;
      o_half = (longint'(os) * mnr) / 2;   // truncates toward zero
      ic     = longint'(r.center_index);

      if (is == q_sz || (is == h_sz && os == q_sz)) begin
         m0 = ic + h_maj;
         push_triangle(ic, m0 - h_min, m0 + h_min);
      end else if (is == h_sz) begin
         m0 = ic + h_maj;
         push_triangle(ic, m0 - h_min, m0);
         push_triangle(ic, m0, m0 + h_min);
      end else begin
         r0 = ic;
         r1 = ic + i_maj;
         range_len = h_sz;
         if (is != os) range_len -= is;
         for (i = 0; i < range_len; i += is) begin
            p00 = r0; p01 = r0 + i_min; p10 = r1; p11 = r1 + i_min;
            q00 = r0; q01 = r0 - i_min; q10 = r1; q11 = r1 - i_min;
            for (j = 0; j < i; j += is) begin
               push_triangle(p00, p10, p11);
               push_triangle(p00, p11, p01);
               push_triangle(q00, q11, q10);
               push_triangle(q00, q01, q11);
               p00 += i_min; p01 += i_min; p10 += i_min; p11 += i_min;
               q00 -= i_min; q01 -= i_min; q10 -= i_min; q11 -= i_min;
            end
            push_triangle(p00, p10, p11);
            push_triangle(q00, q11, q10);
            r0 += i_maj;
            r1 += i_maj;
         end
         // stitch fans only where the edge scale differs from the interior, but not full-coarse
         if (is != os && os != q_sz) begin
            a10 = r1; a11 = r1 + o_min; ac = r0 + o_half;
            b10 = r1; b11 = r1 - o_min; bc = r0 - o_half;
            subs = os / is / 2;
            for (i = 0; i < h_sz; i += os) begin
               ac0 = ac; ac1 = ac - i_min; ax0 = ac; ax1 = ac + i_min;
               bc0 = bc; bc1 = bc + i_min; bx0 = bc; bx1 = bc - i_min;
               push_triangle(a10, a11, ac);
               push_triangle(b10, bc, b11);
               for (j = 0; j < subs; j++) begin
                  push_triangle(a10, ac0, ac1);
                  push_triangle(b10, bc1, bc0);
                  if ((i + os) != h_sz || (j + 1) != subs) begin
                     push_triangle(a11, ax1, ax0);
                     push_triangle(b11, bx0, bx1);
                  end
                  ac0 -= i_min; ac1 -= i_min; ax0 += i_min; ax1 += i_min;
                  bc0 += i_min; bc1 += i_min; bx0 -= i_min; bx1 -= i_min;
               end
               a10 += o_min; a11 += o_min; ac += o_min;
               b10 -= o_min; b11 -= o_min; bc -= o_min;
            end
         end
      end
      if (triangle_q.size() > first) triangle_q[$].last_triangle = 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_t;
      if (reset) begin
         grid_stride = RowStrideReset;
         size_log    = PatchSizeLogReset;
         triangle_q.delete();
         fail_count  = 0;
      end else begin
         if (rsp_valid) begin
            if (triangle_q.size() == 0) begin
               $display("%0t: unexpected triangle %h", $time, rsp_data);
               fail_count++;
            end else begin
               exp_t = triangle_q.pop_front();
               if (rsp_data.vertex_a !== exp_t.vertex_a) begin
                  $display("%0t: vertex_a exp %h got %h", $time,
                           exp_t.vertex_a, rsp_data.vertex_a);
                  fail_count++;
               end
               if (rsp_data.vertex_b !== exp_t.vertex_b) begin
                  $display("%0t: vertex_b exp %h got %h", $time,
                           exp_t.vertex_b, rsp_data.vertex_b);
                  fail_count++;
               end
               if (rsp_data.vertex_c !== exp_t.vertex_c) begin
                  $display("%0t: vertex_c exp %h got %h", $time,
                           exp_t.vertex_c, rsp_data.vertex_c);
                  fail_count++;
               end
               if (rsp_data.last_triangle !== exp_t.last_triangle) begin
                  $display("%0t: last_triangle exp %b got %b", $time,
                           exp_t.last_triangle, rsp_data.last_triangle);
                  fail_count++;
               end
            end
         end
         if (start && !busy) predict_wedge(req_data);
         if (csr_wr_en) begin
            if (csr_index == CsrRowStride) grid_stride = csr_wdata[StrideW-1:0];
            else if (csr_index == CsrPatchSizeLog) size_log = csr_wdata[PslW-1:0];
         end
      end
      triangles_owed = triangle_q.size();
   end

endmodule

[verif/tb_terrain_patch_edge_triangles_core.sv]
// ============================================================================
// tb_terrain_patch_edge_triangles_core
// Drives wedge requests and register writes into the triangle generator:
// a directed sweep of sides and detail levels, then random phases under
// several grid strides and patch sizes. The checker judges every triangle.
// ============================================================================
module tb_terrain_patch_edge_triangles_core;
   import tpe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandPerPhase  = 40;
   localparam int CalmTail      = 15;    // last items of a phase sent back to back
   localparam int SettleCycles  = 40;
   localparam int StallLimit    = 5000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   int                  fail_count;
   int                  triangles_owed;
   int                  quiet_cycles;

   terrain_patch_edge_triangles_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   terrain_patch_edge_triangles_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .triangles_owed (triangles_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: any cycle without a request or result transfer counts.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // All driving happens at the falling edge, so blocking writes are safe.
   task automatic send_wedge(logic [IndexWidth-1:0] center, logic [SideW-1:0] sd,
                             logic [ScaleW-1:0] inner, logic [ScaleW-1:0] outer);
      start                    = 1'b1;
      req_data.center_index    = center;
      req_data.side            = sd;
      req_data.inner_scale_log = inner;
      req_data.outer_scale_log = outer;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle_burst();
      start = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clock);
   endtask

   // Hold requests until every triangle owed has arrived.
   task automatic drain();
      start = 1'b0;
      while (triangles_owed != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_phase(int count);
      for (int k = 0; k < count; k++) begin
         if (k < count - CalmTail && $urandom_range(0, 3) == 0) idle_burst();
         send_wedge(IndexWidth'($urandom()), SideW'($urandom_range(0, 3)),
                    ScaleW'($urandom_range(0, 3)), ScaleW'($urandom_range(0, 3)));
      end
      drain();
   endtask

   initial begin
      logic [ScaleW-1:0] inner_set[6] = '{2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};
      logic [ScaleW-1:0] outer_set[6] = '{2'd3, 2'd3, 2'd2, 2'd3, 2'd1, 2'd2};
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = CsrRowStride;
      csr_wdata = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: each side against coarse cap, half level, rows and fans,
      // at both ends of the index range.
      for (int s = 0; s < 4; s++) begin
         for (int c = 0; c < 6; c++) begin
            if (c == 2) idle_burst();
            send_wedge((c % 2) ? {IndexWidth{1'b1}} : '0, SideW'(s),
                       inner_set[c], outer_set[c]);
         end
      end
      drain();

      // Random at reset settings, then smallest legal, widest, and
      // out-of-range values that saturate inside the block.
      random_phase(RandPerPhase);
      write_reg(CsrRowStride, 13'd5);
      write_reg(CsrPatchSizeLog, 13'd2);
      random_phase(RandPerPhase);
      write_reg(CsrRowStride, 13'd4097);
      write_reg(CsrPatchSizeLog, 13'd3);
      random_phase(RandPerPhase);
      write_reg(CsrRowStride, 13'h1FFF);
      write_reg(CsrPatchSizeLog, 13'd0);
      random_phase(RandPerPhase);
      write_reg(CsrRowStride, 13'd0);
      write_reg(CsrPatchSizeLog, 13'd1);
      random_phase(RandPerPhase / 2);
      write_reg(CsrRowStride, CsrDataW'($urandom_range(5, 8191)));
      write_reg(CsrPatchSizeLog, 13'd3);
      random_phase(RandPerPhase);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/tpe_pkg.sv
hw/rtl/tpe_coord_unit.sv
hw/rtl/terrain_patch_edge_triangles_core.sv
hw/rtl/tpe_checker.sv
verif/terrain_patch_edge_triangles_checker.sv
verif/tb_terrain_patch_edge_triangles_core.sv
